/* rtl/core/ttoc_pkg.sv */
// Shared types, constants and a lookup function for the OLED text column renderer.
package ttoc_pkg;

	localparam int DISPLAY_WIDTH_DEF = 128;
	localparam int GLYPH_COUNT_DEF   = 128;
	localparam int GLYPH_COLS        = 5;

	// item function codes
	localparam logic [1:0] FUNC_RENDER = 2'd0;
	localparam logic [1:0] FUNC_POS    = 2'd1;
	localparam logic [1:0] FUNC_LOAD   = 2'd2;

	localparam logic [7:0] CHAR_CR       = 8'd13;
	localparam logic [6:0] QUESTION_SLOT = 7'd31;

	// controller command bases
	localparam logic [7:0] CMD_PAGE   = 8'hB0;
	localparam logic [7:0] CMD_COL_LO = 8'h00;
	localparam logic [7:0] CMD_COL_HI = 8'h10;

	// each bit of a nibble repeated twice
	localparam logic [7:0] NIB_DOUBLE [16] = '{
		8'h00, 8'h03, 8'h0C, 8'h0F, 8'h30, 8'h33, 8'h3C, 8'h3F,
		8'hC0, 8'hC3, 8'hCC, 8'hCF, 8'hF0, 8'hF3, 8'hFC, 8'hFF
	};

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] char_code;
		logic [6:0] column;
		logic [2:0] page;
		logic [6:0] glyph_index;
		logic [2:0] glyph_column;
		logic [7:0] glyph_bits;
	} cmd_item_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] out_byte;
		logic       last;
	} res_item_t;

	typedef enum logic [1:0] {
		FM_NONE,
		FM_RAW,
		FM_LO,
		FM_HI
	} font_mode_t;

	// one output byte as issued by the sequencer
	typedef struct packed {
		logic       is_data;
		logic [7:0] cmd_byte;
		font_mode_t mode;
		logic       last;
	} step_t;

	function automatic logic [6:0] glyph_slot(input logic [7:0] code);
		logic [6:0] slot;
		slot = QUESTION_SLOT;
		if (code >= 8'd32 && code <= 8'h7A) begin
			slot = 7'(code - 8'd32);
		end else begin
			case (code)
				8'hB0:   slot = 7'd91;
				8'hC4:   slot = 7'd93;
				8'hD6:   slot = 7'd94;
				8'hDC:   slot = 7'd95;
				8'hE4:   slot = 7'd96;
				8'hF6:   slot = 7'd97;
				8'hFC:   slot = 7'd98;
				8'hDF:   slot = 7'd99;
				default: slot = QUESTION_SLOT;
			endcase
		end
		return slot;
	endfunction

endpackage

/* rtl/core/text_to_oled_column_renderer.sv */
// The first byte of a transaction passes the sequencer state, the s1 stage with its font read and the output register.
// Throughput: one output byte per cycle while res_ready holds; a render or position
// transaction yields 3 to 33 bytes, loads and unused codes none.
// The next transaction is taken in the cycle the previous last byte leaves the sequencer.
// Reset: cursor at column 0 page 0, single size, pipeline empty; font store not cleared.
module text_to_oled_column_renderer #(
	parameter int DISPLAY_WIDTH = ttoc_pkg::DISPLAY_WIDTH_DEF,
	parameter int GLYPH_COUNT   = ttoc_pkg::GLYPH_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  ttoc_pkg::cmd_item_t cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output ttoc_pkg::res_item_t res,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);

	localparam int FONT_DEPTH = GLYPH_COUNT * ttoc_pkg::GLYPH_COLS;
	localparam int AW         = $clog2(FONT_DEPTH);

	logic            take;
	logic            step_valid;
	ttoc_pkg::step_t step;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [7:0]      ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [7:0]      font_data;

	ttoc_seq #(
		.DISPLAY_WIDTH (DISPLAY_WIDTH),
		.GLYPH_COUNT   (GLYPH_COUNT),
		.AW            (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.take       (take),
		.step_valid (step_valid),
		.step       (step),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr)
	);

	ttoc_ram #(
		.WIDTH (8),
		.DEPTH (FONT_DEPTH),
		.AW    (AW)
	) u_font (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (take),
		.raddr (ram_raddr),
		.rdata (font_data)
	);

	ttoc_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_valid (step_valid),
		.step       (step),
		.take       (take),
		.font_data  (font_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule

/* rtl/core/ttoc_ram.sv */
// Generic simple dual-port RAM with registered read.
module ttoc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 640,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/ttoc_seq.sv */
// Byte sequencer: cursor, wrap decisions, command generation and font addressing.
module ttoc_seq #(
	parameter int DISPLAY_WIDTH = ttoc_pkg::DISPLAY_WIDTH_DEF,
	parameter int GLYPH_COUNT   = ttoc_pkg::GLYPH_COUNT_DEF,
	parameter int AW            = $clog2(GLYPH_COUNT * ttoc_pkg::GLYPH_COLS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  ttoc_pkg::cmd_item_t cmd,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                take,
	output logic                step_valid,
	output ttoc_pkg::step_t     step,
	output logic                ram_we,
	output logic [AW-1:0]       ram_waddr,
	output logic [7:0]          ram_wdata,
	output logic [AW-1:0]       ram_raddr
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETPOS,
		S_NL,
		S_LO,
		S_MID,
		S_HI,
		S_EOL,
		S_PAD1,
		S_BACK,
		S_PAD
	} state_t;

	localparam logic [8:0] WIDTH9    = 9'(DISPLAY_WIDTH);
	localparam logic [8:0] WRAP_SGL  = 9'(DISPLAY_WIDTH - 5);
	localparam logic [8:0] WRAP_DBL  = 9'(DISPLAY_WIDTH - 10);

	state_t      state_q, state_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [7:0]  col_q, col_d;
	logic [2:0]  page_q, page_d;
	logic        dbl_q;

	// per-item payload
	logic        is_cr_q;
	logic [6:0]  pos_x_q;
	logic [2:0]  pos_y_q;
	logic [8:0]  base_q;

	logic        accept;
	logic        seg_end;
	logic        last_step;
	logic [3:0]  seg_len;
	logic [6:0]  pos_x;
	logic [2:0]  pos_y;
	logic        is_pos;
	logic [3:0]  col_off;
	logic [8:0]  sum6, sum12;
	logic [6:0]  slot;
	logic [9:0]  wr_sum;
	logic [6:0]  col_back;

	assign accept = cmd_valid && cmd_ready;
	assign slot   = ttoc_pkg::glyph_slot(cmd.char_code);
	assign sum6   = {1'b0, col_q} + 9'd6;
	assign sum12  = {1'b0, col_q} + 9'd12;
	assign col_back = 7'(col_q - 8'd2);

	// segment length and position target per state
	always_comb begin
		seg_len = 4'd3;
		pos_x   = 7'd0;
		pos_y   = page_q;
		is_pos  = 1'b0;
		case (state_q)
			S_SETPOS: begin
				is_pos = 1'b1;
				pos_x  = pos_x_q;
				pos_y  = pos_y_q;
			end
			S_NL: begin
				is_pos = 1'b1;
				pos_y  = dbl_q ? page_q + 3'd2 : page_q + 3'd1;
			end
			S_MID: begin
				is_pos = 1'b1;
				pos_x  = col_q[6:0];
				pos_y  = page_q + 3'd1;
			end
			S_EOL: begin
				is_pos = 1'b1;
				pos_y  = page_q + 3'd1;
			end
			S_BACK: begin
				is_pos = 1'b1;
				pos_x  = col_back;
				pos_y  = page_q + 3'd7;
			end
			S_LO:    seg_len = dbl_q ? 4'd10 : 4'd5;
			S_HI:    seg_len = 4'd10;
			S_PAD1:  seg_len = 4'd2;
			S_PAD:   seg_len = dbl_q ? 4'd2 : 4'd1;
			default: seg_len = 4'd1;
		endcase
	end

	assign seg_end = (cnt_q == seg_len - 4'd1);

	always_comb begin
		case (state_q)
			S_SETPOS, S_EOL, S_PAD: last_step = seg_end;
			S_NL:                   last_step = seg_end && is_cr_q;
			default:                last_step = 1'b0;
		endcase
	end

	assign cmd_ready  = (state_q == S_IDLE) || (take && last_step);
	assign step_valid = (state_q != S_IDLE);

	// step descriptor
	always_comb begin
		step.is_data  = !is_pos;
		step.cmd_byte = 8'h00;
		step.mode     = ttoc_pkg::FM_NONE;
		step.last     = last_step;
		col_off       = cnt_q;
		if (is_pos) begin
			case (cnt_q)
				4'd0:    step.cmd_byte = ttoc_pkg::CMD_PAGE | {5'd0, pos_y};
				4'd1:    step.cmd_byte = ttoc_pkg::CMD_COL_LO | {4'd0, pos_x[3:0]};
				default: step.cmd_byte = ttoc_pkg::CMD_COL_HI | {5'd0, pos_x[6:4]};
			endcase
		end else if (state_q == S_LO) begin
			step.mode = dbl_q ? ttoc_pkg::FM_LO : ttoc_pkg::FM_RAW;
			col_off   = dbl_q ? {1'b0, cnt_q[3:1]} : cnt_q;
		end else if (state_q == S_HI) begin
			step.mode = ttoc_pkg::FM_HI;
			col_off   = {1'b0, cnt_q[3:1]};
		end
	end

	assign ram_raddr = AW'(base_q + {5'd0, col_off});

	// glyph column load goes straight to the store
	assign wr_sum    = {1'b0, cmd.glyph_index, 2'b00} + {3'd0, cmd.glyph_index}
	                 + {7'd0, cmd.glyph_column};
	assign ram_we    = accept && (cmd.func == ttoc_pkg::FUNC_LOAD)
	                 && (cmd.glyph_column <= 3'd4)
	                 && (32'(cmd.glyph_index) < GLYPH_COUNT);
	assign ram_waddr = AW'(wr_sum);
	assign ram_wdata = cmd.glyph_bits;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		col_d   = col_q;
		page_d  = page_q;
		if (take && state_q != S_IDLE) begin
			if (!seg_end) begin
				cnt_d = cnt_q + 4'd1;
			end else begin
				cnt_d = 4'd0;
				if (is_pos) begin
					col_d  = {1'b0, pos_x};
					page_d = pos_y;
				end
				unique case (state_q)
					S_SETPOS, S_EOL: state_d = S_IDLE;
					S_NL:            state_d = is_cr_q ? S_IDLE : S_LO;
					S_LO: begin
						if (dbl_q) begin
							state_d = S_MID;
						end else begin
							col_d   = sum6[7:0];
							state_d = (sum6 >= WIDTH9) ? S_EOL : S_PAD;
						end
					end
					S_MID: state_d = S_HI;
					S_HI: begin
						col_d   = sum12[7:0];
						state_d = (sum12 >= WIDTH9) ? S_EOL : S_PAD1;
					end
					S_PAD1: state_d = S_BACK;
					S_BACK: state_d = S_PAD;
					S_PAD: begin
						if (dbl_q) begin
							col_d = col_q + 8'd2;
						end
						state_d = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
		end
		// next transaction sees the cursor as left by the previous one
		if (accept) begin
			cnt_d = 4'd0;
			case (cmd.func)
				ttoc_pkg::FUNC_RENDER: begin
					if (cmd.char_code == ttoc_pkg::CHAR_CR) begin
						state_d = S_NL;
					end else if ({1'b0, col_d} > (dbl_q ? WRAP_DBL : WRAP_SGL)) begin
						state_d = S_NL;
					end else begin
						state_d = S_LO;
					end
				end
				ttoc_pkg::FUNC_POS: state_d = S_SETPOS;
				default:            state_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= 4'd0;
			col_q   <= 8'd0;
			page_q  <= 3'd0;
			dbl_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			col_q   <= col_d;
			page_q  <= page_d;
			if (cfg_we) begin
				dbl_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_cr_q <= (cmd.char_code == ttoc_pkg::CHAR_CR);
			pos_x_q <= cmd.column;
			pos_y_q <= cmd.page;
			base_q  <= {slot, 2'b00} + {2'd0, slot};
		end
	end

endmodule

/* rtl/core/ttoc_out.sv */
// Font read stage and output register; expands glyph nibbles for double size.
module ttoc_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_valid,
	input  ttoc_pkg::step_t     step,
	output logic                take,
	input  logic [7:0]          font_data,
	output logic                res_valid,
	input  logic                res_ready,
	output ttoc_pkg::res_item_t res
);

	logic                s1_valid_q;
	ttoc_pkg::step_t     step_s1;
	logic                res_valid_q;
	ttoc_pkg::res_item_t res_s2;
	logic                s2_load;
	logic [7:0]          byte_val;

	assign s2_load = !res_valid_q || res_ready;
	// the font read is issued together with the s1 load, so both stall as one
	assign take    = !s1_valid_q || s2_load;

	always_comb begin
		case (step_s1.mode)
			ttoc_pkg::FM_RAW: byte_val = font_data;
			ttoc_pkg::FM_LO:  byte_val = ttoc_pkg::NIB_DOUBLE[font_data[3:0]];
			ttoc_pkg::FM_HI:  byte_val = ttoc_pkg::NIB_DOUBLE[font_data[7:4]];
			default:          byte_val = step_s1.cmd_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				s1_valid_q <= step_valid;
			end
			if (s2_load) begin
				res_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			step_s1 <= step;
		end
		if (s2_load) begin
			res_s2.is_data  <= step_s1.is_data;
			res_s2.out_byte <= byte_val;
			res_s2.last     <= step_s1.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_s2;

endmodule

/* bench/oled_byte_checker.sv */
`timescale 1ns / 1ps
// Byte stream checker for the OLED text renderer: predicts and compares result bytes.
module oled_byte_checker #(
	parameter int DISPLAY_WIDTH = ttoc_pkg::DISPLAY_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic                cmd_ready,
	input  ttoc_pkg::cmd_item_t cmd,
	input  logic                res_valid,
	input  logic                res_ready,
	input  ttoc_pkg::res_item_t res,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	output int unsigned         bytes_due,
	output int unsigned         mismatch_count
);
	import ttoc_pkg::*;

	logic [7:0]  col_q;
	logic [2:0]  page_q;
	logic        wide_q;
	logic [7:0]  font_mem [GLYPH_COUNT_DEF * GLYPH_COLS];
	res_item_t   predicted_bytes [$];
	res_item_t   want;
	int unsigned byte_seq;

	task automatic report_mismatch(input string what);
		$display("[%0t] byte %0d mismatch: %s", $time, byte_seq, what);
		mismatch_count++;
	endtask

	function automatic void queue_byte(input logic is_data, input logic [7:0] value);
		res_item_t r;
		r.is_data = is_data;
		r.out_byte = value;
		r.last = 1'b0;
		predicted_bytes.push_back(r);
	endfunction

	function automatic void set_cursor(input logic [6:0] x, input logic [2:0] y);
		queue_byte(1'b0, CMD_PAGE | {5'd0, y});
		queue_byte(1'b0, CMD_COL_LO | {4'd0, x[3:0]});
		queue_byte(1'b0, CMD_COL_HI | {5'd0, x[6:4]});
		page_q = y;
		col_q = {1'b0, x};
	endfunction

	function automatic int font_slot(input logic [7:0] code);
		if (code < 8'd32)
			return int'(QUESTION_SLOT);
		if (code <= 8'h7A)
			return code - 32;
		case (code)
			8'hB0: return 91;  // degree sign
			8'hC4: return 93;
			8'hD6: return 94;
			8'hDC: return 95;
			8'hE4: return 96;
			8'hF6: return 97;
			8'hFC: return 98;
			8'hDF: return 99;  // sharp s
			default: return int'(QUESTION_SLOT);
		endcase
	endfunction

	// every nibble bit doubled into two adjacent pixel rows
	function automatic logic [7:0] widen_nibble(input logic [3:0] n);
		logic [7:0] w;
		for (int k = 0; k < 4; k++) begin
			w[2 * k] = n[k];
			w[2 * k + 1] = n[k];
		end
		return w;
	endfunction

	function automatic void render_narrow(input logic [7:0] code);
		int slot;
		if (code == CHAR_CR) begin
			set_cursor(7'd0, page_q + 3'd1);
			return;
		end
		if (col_q > DISPLAY_WIDTH - 5)
			set_cursor(7'd0, page_q + 3'd1);
		slot = font_slot(code);
		for (int i = 0; i < GLYPH_COLS; i++)
			queue_byte(1'b1, font_mem[slot * GLYPH_COLS + i]);
		col_q = col_q + 8'd6;
		// spacer column is dropped when the glyph ends the line
		if (col_q >= DISPLAY_WIDTH)
			set_cursor(7'd0, page_q + 3'd1);
		else
			queue_byte(1'b1, 8'h00);
	endfunction

	function automatic void render_wide(input logic [7:0] code);
		int slot;
		logic [7:0] half;
		if (code == CHAR_CR) begin
			set_cursor(7'd0, page_q + 3'd2);
			return;
		end
		if (col_q > DISPLAY_WIDTH - 10)
			set_cursor(7'd0, page_q + 3'd2);
		slot = font_slot(code);
		for (int i = 0; i < GLYPH_COLS; i++) begin
			half = widen_nibble(font_mem[slot * GLYPH_COLS + i][3:0]);
			queue_byte(1'b1, half);
			queue_byte(1'b1, half);
		end
		set_cursor(col_q[6:0], page_q + 3'd1);
		for (int i = 0; i < GLYPH_COLS; i++) begin
			half = widen_nibble(font_mem[slot * GLYPH_COLS + i][7:4]);
			queue_byte(1'b1, half);
			queue_byte(1'b1, half);
		end
		col_q = col_q + 8'd12;
		if (col_q >= DISPLAY_WIDTH) begin
			set_cursor(7'd0, page_q + 3'd1);
		end else begin
			// double spacer on the lower page, then back up for the upper one
			queue_byte(1'b1, 8'h00);
			queue_byte(1'b1, 8'h00);
			set_cursor(7'(col_q - 8'd2), page_q + 3'd7);
			queue_byte(1'b1, 8'h00);
			queue_byte(1'b1, 8'h00);
			col_q = col_q + 8'd2;
		end
	endfunction

	function automatic void predict_item(input cmd_item_t item);
		res_item_t tail;
		int unsigned first;
		first = predicted_bytes.size();
		case (item.func)
			FUNC_RENDER: begin
				if (wide_q)
					render_wide(item.char_code);
				else
					render_narrow(item.char_code);
			end
			FUNC_POS: set_cursor(item.column, item.page);
			FUNC_LOAD: begin
				if (item.glyph_column < GLYPH_COLS && item.glyph_index < GLYPH_COUNT_DEF)
					font_mem[item.glyph_index * GLYPH_COLS + item.glyph_column] = item.glyph_bits;
			end
			default: ;
		endcase
		if (predicted_bytes.size() > first) begin
			tail = predicted_bytes.pop_back();
			tail.last = 1'b1;
			predicted_bytes.push_back(tail);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q = '0;
			page_q = '0;
			wide_q = 1'b0;
			predicted_bytes.delete();
			bytes_due <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (predicted_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected is_data %0b byte %02h last %0b",
						res.is_data, res.out_byte, res.last));
				end else begin
					want = predicted_bytes.pop_front();
					if (res.is_data !== want.is_data)
						report_mismatch($sformatf("is_data %0b, want %0b", res.is_data, want.is_data));
					if (res.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %02h, want %02h",
							res.out_byte, want.out_byte));
					if (res.last !== want.last)
						report_mismatch($sformatf("last %0b, want %0b", res.last, want.last));
				end
				byte_seq++;
			end
			if (cfg_we)
				wide_q = cfg_wdata;
			if (cmd_valid && cmd_ready)
				predict_item(cmd);
			bytes_due <= predicted_bytes.size();
		end
	end

endmodule

/* bench/tb_text_to_oled_column_renderer.sv */
`timescale 1ns / 1ps
// Testbench top for the OLED text renderer: drives transactions, size mode and verdict.
module tb_text_to_oled_column_renderer;
	import ttoc_pkg::*;

	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 40;
	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 24;
	localparam int PHASES        = 6;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [7:0] LATIN_SPECIALS [0:7] = '{
		8'hB0, 8'hC4, 8'hD6, 8'hDC, 8'hE4, 8'hF6, 8'hFC, 8'hDF
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	cmd_item_t   cmd = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_item_t   res;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	int unsigned bytes_due;
	int unsigned mismatch_count;
	int unsigned quiet_cycles = 0;
	int unsigned items_sent = 0;
	bit          steady_cmd = 1'b0;
	bit [4:0]    cols_loaded [GLYPH_COUNT_DEF];

	always #1 clk = ~clk;

	text_to_oled_column_renderer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	oled_byte_checker byte_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.bytes_due      (bytes_due),
		.mismatch_count (mismatch_count)
	);

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic cmd_item_t random_item();
		cmd_item_t item;
		item.func = 2'($urandom_range(0, 3));
		item.char_code = 8'($urandom_range(0, 255));
		item.column = 7'($urandom_range(0, 127));
		item.page = 3'($urandom_range(0, 7));
		item.glyph_index = 7'($urandom_range(0, 127));
		item.glyph_column = 3'($urandom_range(0, 7));
		item.glyph_bits = 8'($urandom_range(0, 255));
		return item;
	endfunction

	function automatic logic [7:0] pick_code();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return CHAR_CR;
		if (r < 23)
			return LATIN_SPECIALS[3'($urandom_range(0, 7))];
		if (r < 33)
			return 8'($urandom_range(0, 31));
		if (r < 43)
			return 8'($urandom_range(123, 255));
		return 8'($urandom_range(32, 122));
	endfunction

	task automatic send_item(input cmd_item_t item);
		int unsigned gap;
		cmd <= item;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		items_sent++;
		gap = steady_cmd ? 0 : idle_len();
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_load(input logic [6:0] slot, input logic [2:0] col,
		input logic [7:0] bits);
		cmd_item_t item;
		item = random_item();
		item.func = FUNC_LOAD;
		item.glyph_index = slot;
		item.glyph_column = col;
		item.glyph_bits = bits;
		send_item(item);
		if (col < GLYPH_COLS)
			cols_loaded[slot][col] = 1'b1;
	endtask

	task automatic send_pos(input logic [6:0] column, input logic [2:0] page);
		cmd_item_t item;
		item = random_item();
		item.func = FUNC_POS;
		item.column = column;
		item.page = page;
		send_item(item);
	endtask

	// fills any font columns the glyph still lacks before rendering it
	task automatic send_render(input logic [7:0] code);
		cmd_item_t item;
		logic [6:0] slot;
		if (code != CHAR_CR) begin
			slot = glyph_slot(code);
			for (int c = 0; c < GLYPH_COLS; c++)
				if (!cols_loaded[slot][c])
					send_load(slot, 3'(c), 8'($urandom_range(0, 255)));
		end
		item = random_item();
		item.func = FUNC_RENDER;
		item.char_code = code;
		send_item(item);
	endtask

	task automatic send_unused();
		cmd_item_t item;
		item = random_item();
		item.func = FUNC_UNUSED;
		send_item(item);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (bytes_due != 0)
			@(posedge clk);
		// loads yield no bytes but may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic wide);
		cfg_we <= 1'b1;
		cfg_wdata <= wide;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_step();
		int unsigned pick;
		int unsigned run;
		logic [2:0] col;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			run = $urandom_range(1, 3);
			repeat (run) send_render(pick_code());
		end else if (pick < 60) begin
			if ($urandom_range(0, 1))
				send_pos(7'($urandom_range(108, 127)), 3'($urandom_range(0, 7)));
			else
				send_pos(7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
		end else if (pick < 75) begin
			col = 3'($urandom_range(0, 7));
			send_load(7'($urandom_range(0, 127)), col, 8'($urandom_range(0, 255)));
		end else if (pick < 85) begin
			send_render(CHAR_CR);
		end else if (pick < 91) begin
			send_unused();
		end else begin
			// hold off until the renderer has flushed everything
			wait_drained();
			send_render(pick_code());
		end
	endtask

	initial begin : drain_side
		int unsigned span;
		while (!arst_n)
			@(posedge clk);
		forever begin
			span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
			res_ready <= 1'b1;
			repeat (span) @(posedge clk);
			span = idle_len();
			if (span != 0) begin
				res_ready <= 1'b0;
				repeat (span) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic wide;
		int unsigned goal;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single size: field extremes, '?' fallbacks, special glyphs, wraps
		write_mode(1'b0);
		send_load(7'd0, 3'd0, 8'h00);
		send_load(7'd127, 3'd4, 8'hFF);
		send_load(7'd5, 3'd7, 8'hA5);
		send_render("A");
		send_render(8'd0);
		send_render(8'd31);
		send_render(8'd255);
		send_render(8'h7A);
		send_render(8'h7B);
		send_render(8'h20);
		foreach (LATIN_SPECIALS[k])
			send_render(LATIN_SPECIALS[k]);
		send_render(CHAR_CR);
		send_pos(7'd127, 3'd7);
		send_render("A");
		send_pos(7'd122, 3'd3);
		send_render("z");
		send_unused();

		// double size: line full, glyph ending the line, carriage return
		wait_drained();
		write_mode(1'b1);
		send_pos(7'd0, 3'd0);
		send_render("A");
		send_render(CHAR_CR);
		send_pos(7'd118, 3'd6);
		send_render("z");
		send_pos(7'd119, 3'd7);
		send_render("A");

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			wide = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
			write_mode(wide);
			steady_cmd = (phase == 2 || phase == 3);
			goal = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < goal)
				random_step();
		end

		steady_cmd = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
rtl/core/ttoc_pkg.sv
rtl/core/ttoc_ram.sv
rtl/core/ttoc_seq.sv
rtl/core/ttoc_out.sv
rtl/core/text_to_oled_column_renderer.sv
bench/oled_byte_checker.sv
bench/tb_text_to_oled_column_renderer.sv
